[hw/rtl/pis_pkg.sv]
package pis_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int DEB_BITS    = 8;
    localparam int ICNT_BITS   = 9;
    localparam int REG_IDX_BITS = 3;
    localparam int PADDR_BITS  = 5;
    localparam int PDATA_BITS  = 32;

    // register indexes, byte address is 4 * index
    localparam logic [REG_IDX_BITS-1:0] REG_VBAT_THRESHOLD = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_VBAT_DEBOUNCE  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_IGN_LOW        = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_IGN_HIGH       = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_IGN_DEBOUNCE   = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_FAULT_DEBOUNCE = 3'd5;

    localparam logic [SAMPLE_BITS-1:0] VBAT_THRESHOLD_RST = SAMPLE_BITS'(670);
    localparam logic [DEB_BITS-1:0]    VBAT_DEBOUNCE_RST  = 8'd3;
    localparam logic [SAMPLE_BITS-1:0] IGN_LOW_RST        = SAMPLE_BITS'(410);
    localparam logic [SAMPLE_BITS-1:0] IGN_HIGH_RST       = SAMPLE_BITS'(665);
    localparam logic [DEB_BITS-1:0]    IGN_DEBOUNCE_RST   = 8'd10;
    localparam logic [DEB_BITS-1:0]    FAULT_DEBOUNCE_RST = 8'd200;

    localparam logic [ICNT_BITS-1:0] IGN_HOLD_COUNT = 9'd100;
    localparam logic [7:0]           WAKE_STANDBY   = 8'd2;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] vbat_threshold;
        logic [DEB_BITS-1:0]    vbat_debounce;
        logic [SAMPLE_BITS-1:0] ign_low_threshold;
        logic [SAMPLE_BITS-1:0] ign_high_threshold;
        logic [DEB_BITS-1:0]    ign_debounce;
        logic [DEB_BITS-1:0]    fault_debounce;
    } pis_cfg_t;

endpackage

[hw/rtl/pis_regs.sv]
module pis_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pis_pkg::PADDR_BITS-1:0] paddr,
    input  logic [pis_pkg::PDATA_BITS-1:0] pwdata,
    output logic [pis_pkg::PDATA_BITS-1:0] prdata,
    output logic                          pready,
    output pis_pkg::pis_cfg_t             cfg
);
    import pis_pkg::*;

    pis_cfg_t               cfg_reg;
    logic                   wr_en;
    logic [REG_IDX_BITS-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[PADDR_BITS-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vbat_threshold     <= VBAT_THRESHOLD_RST;
            cfg_reg.vbat_debounce      <= VBAT_DEBOUNCE_RST;
            cfg_reg.ign_low_threshold  <= IGN_LOW_RST;
            cfg_reg.ign_high_threshold <= IGN_HIGH_RST;
            cfg_reg.ign_debounce       <= IGN_DEBOUNCE_RST;
            cfg_reg.fault_debounce     <= FAULT_DEBOUNCE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_VBAT_THRESHOLD: cfg_reg.vbat_threshold     <= pwdata[SAMPLE_BITS-1:0];
                REG_VBAT_DEBOUNCE:  cfg_reg.vbat_debounce      <= pwdata[DEB_BITS-1:0];
                REG_IGN_LOW:        cfg_reg.ign_low_threshold  <= pwdata[SAMPLE_BITS-1:0];
                REG_IGN_HIGH:       cfg_reg.ign_high_threshold <= pwdata[SAMPLE_BITS-1:0];
                REG_IGN_DEBOUNCE:   cfg_reg.ign_debounce       <= pwdata[DEB_BITS-1:0];
                REG_FAULT_DEBOUNCE: cfg_reg.fault_debounce     <= pwdata[DEB_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_VBAT_THRESHOLD: prdata = PDATA_BITS'(cfg_reg.vbat_threshold);
            REG_VBAT_DEBOUNCE:  prdata = PDATA_BITS'(cfg_reg.vbat_debounce);
            REG_IGN_LOW:        prdata = PDATA_BITS'(cfg_reg.ign_low_threshold);
            REG_IGN_HIGH:       prdata = PDATA_BITS'(cfg_reg.ign_high_threshold);
            REG_IGN_DEBOUNCE:   prdata = PDATA_BITS'(cfg_reg.ign_debounce);
            REG_FAULT_DEBOUNCE: prdata = PDATA_BITS'(cfg_reg.fault_debounce);
            default:            prdata = '0;
        endcase
    end

endmodule

[hw/rtl/power_input_supervisor_top.sv]
// The result word is registered at the edge that accepts the sample word.
// Throughput: one word per cycle; the result register frees itself in the cycle it is taken,
// so in_ready falls only while a result waits and out_ready is low.
// Reset: rst_n clears all counters, flags and the result valid at once, and loads the
// configuration registers with their default thresholds and debounce counts.
module power_input_supervisor_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pis_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [pis_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [pis_pkg::PDATA_BITS-1:0]  prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pis_pkg::SAMPLE_BITS-1:0] battery_sample,
    input  logic [pis_pkg::SAMPLE_BITS-1:0] ignition_sample,
    input  logic                            fault_pin,
    input  logic [7:0]                      standby_state,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            battery_ok,
    output logic                            ignition_on,
    output logic                            regulator_fault,
    output logic                            power_state,
    output logic                            ignition_off_seen,
    output logic                            wake_event
);
    import pis_pkg::*;

    pis_cfg_t cfg;

    pis_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [DEB_BITS-1:0]  bat_cnt_reg, bat_cnt_next, bat_cnt_inc;
    logic                 bat_flag_reg, bat_flag_next;
    logic [ICNT_BITS-1:0] ign_cnt_reg, ign_cnt_next, ign_cnt_inc;
    logic                 ign_flag_reg, ign_flag_next;
    logic [DEB_BITS-1:0]  flt_cnt_reg, flt_cnt_next;
    logic                 flt_flag_reg, flt_flag_next;
    logic                 prev_ign_reg;
    logic                 off_latch_reg, off_latch_next;
    logic                 wake_next;
    logic                 out_valid_reg;
    logic                 wake_reg;
    logic                 accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        // battery: count healthy samples, pin at the debounce value once qualified
        bat_cnt_inc   = (bat_cnt_reg != 8'hFF) ? bat_cnt_reg + 8'd1 : bat_cnt_reg;
        bat_cnt_next  = bat_cnt_reg;
        bat_flag_next = bat_flag_reg;
        if (battery_sample > cfg.vbat_threshold)
        begin
            if (bat_cnt_inc > cfg.vbat_debounce)
            begin
                bat_cnt_next  = cfg.vbat_debounce;
                bat_flag_next = 1'b1;
            end
            else
            begin
                bat_cnt_next = bat_cnt_inc;
            end
        end
        else
        begin
            bat_cnt_next  = '0;
            bat_flag_next = 1'b0;
        end

        // ignition: low test wins, between thresholds hold
        ign_cnt_inc   = (ign_cnt_reg != {ICNT_BITS{1'b1}}) ? ign_cnt_reg + 9'd1 : ign_cnt_reg;
        ign_cnt_next  = ign_cnt_reg;
        ign_flag_next = ign_flag_reg;
        if (ignition_sample < cfg.ign_low_threshold)
        begin
            ign_cnt_next  = '0;
            ign_flag_next = 1'b0;
        end
        else if (ignition_sample > cfg.ign_high_threshold)
        begin
            if (ign_cnt_inc > {1'b0, cfg.ign_debounce})
            begin
                ign_cnt_next  = IGN_HOLD_COUNT;
                ign_flag_next = 1'b1;
            end
            else
            begin
                ign_cnt_next = ign_cnt_inc;
            end
        end

        // regulator fault, active-low pin
        flt_cnt_next  = flt_cnt_reg;
        flt_flag_next = flt_flag_reg;
        if (fault_pin)
        begin
            flt_cnt_next  = '0;
            flt_flag_next = 1'b0;
        end
        else if (flt_cnt_reg < cfg.fault_debounce)
        begin
            flt_cnt_next  = flt_cnt_reg + 8'd1;
            flt_flag_next = 1'b0;
        end
        else
        begin
            flt_flag_next = 1'b1;
        end

        // edges of the qualified ignition flag
        off_latch_next = off_latch_reg;
        wake_next      = 1'b0;
        if (prev_ign_reg && !ign_flag_next)
        begin
            off_latch_next = 1'b1;
        end
        else if (!prev_ign_reg && ign_flag_next)
        begin
            off_latch_next = 1'b0;
            wake_next      = (standby_state == WAKE_STANDBY);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bat_cnt_reg   <= '0;
            bat_flag_reg  <= 1'b0;
            ign_cnt_reg   <= '0;
            ign_flag_reg  <= 1'b0;
            flt_cnt_reg   <= '0;
            flt_flag_reg  <= 1'b0;
            prev_ign_reg  <= 1'b0;
            off_latch_reg <= 1'b0;
            wake_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                bat_cnt_reg   <= bat_cnt_next;
                bat_flag_reg  <= bat_flag_next;
                ign_cnt_reg   <= ign_cnt_next;
                ign_flag_reg  <= ign_flag_next;
                flt_cnt_reg   <= flt_cnt_next;
                flt_flag_reg  <= flt_flag_next;
                prev_ign_reg  <= ign_flag_next;
                off_latch_reg <= off_latch_next;
                wake_reg      <= wake_next;
            end
            // hold the result word until taken, replace it on a new accept
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // the state flags double as the result word
    assign out_valid         = out_valid_reg;
    assign battery_ok        = bat_flag_reg;
    assign ignition_on       = ign_flag_reg;
    assign regulator_fault   = flt_flag_reg;
    assign power_state       = ign_flag_reg;
    assign ignition_off_seen = off_latch_reg;
    assign wake_event        = wake_reg;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted word produced no result");

    a_wake_needs_ignition: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wake_event) |-> ignition_on)
        else $error("wake event without ignition on");

    a_off_latch_clear_when_on: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ignition_on) |-> !ignition_off_seen)
        else $error("off latch set while ignition on");

    a_prev_tracks_flag: assert property (@(posedge clk) disable iff (!rst_n)
        prev_ign_reg == ign_flag_reg)
        else $error("previous ignition out of step with flag");

endmodule

[tb/power_input_supervisor_top_test.sv]
module power_input_supervisor_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pis_pkg::*;

    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

    typedef struct packed {
        logic battery_ok;
        logic ignition_on;
        logic regulator_fault;
        logic power_state;
        logic off_seen;
        logic wake;
    } supervisor_flags_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_BITS-1:0]  paddr = '0;
    logic [PDATA_BITS-1:0]  pwdata = '0;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [SAMPLE_BITS-1:0] battery_sample = '0;
    logic [SAMPLE_BITS-1:0] ignition_sample = '0;
    logic                   fault_pin = 1'b1;
    logic [7:0]             standby_state = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   battery_ok;
    logic                   ignition_on;
    logic                   regulator_fault;
    logic                   power_state;
    logic                   ignition_off_seen;
    logic                   wake_event;

    // supervisor image: configuration and qualification state
    pis_cfg_t         cfg_model = '{VBAT_THRESHOLD_RST, VBAT_DEBOUNCE_RST, IGN_LOW_RST,
                                    IGN_HIGH_RST, IGN_DEBOUNCE_RST, FAULT_DEBOUNCE_RST};
    logic [7:0]       bat_count = '0;
    logic             bat_ok = 1'b0;
    logic [ICNT_BITS-1:0] ign_count = '0;
    logic             ign_on = 1'b0;
    logic [7:0]       flt_count = '0;
    logic             flt_on = 1'b0;
    logic             ign_was_on = 1'b0;
    logic             off_seen = 1'b0;

    supervisor_flags_t flags_due[$];
    int mismatches = 0;

    // sender pacing and receiver hold-off
    int burst_left = 0;
    bit sender_gaps_on = 1'b1;
    bit offering = 1'b0;
    int result_hold_request = 0;

    // level runs of the random stimulus
    int bat_run = 0;
    int ign_run = 0;
    int pin_run = 0;
    int bat_mode = 0;
    int ign_mode = 0;
    bit pin_level = 1'b1;

    power_input_supervisor_top DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .battery_sample    (battery_sample),
        .ignition_sample   (ignition_sample),
        .fault_pin         (fault_pin),
        .standby_state     (standby_state),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .battery_ok        (battery_ok),
        .ignition_on       (ignition_on),
        .regulator_fault   (regulator_fault),
        .power_state       (power_state),
        .ignition_off_seen (ignition_off_seen),
        .wake_event        (wake_event)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic supervisor_flags_t qualify_tick(input logic [SAMPLE_BITS-1:0] bat,
                                                       input logic [SAMPLE_BITS-1:0] ign,
                                                       input logic pin,
                                                       input logic [7:0] standby);
        supervisor_flags_t flags;
        logic wake;
        wake = 1'b0;
        if (bat > cfg_model.vbat_threshold)
        begin
            if (bat_count != 8'hFF)
                bat_count++;
            if (bat_count > cfg_model.vbat_debounce)
            begin
                bat_count = cfg_model.vbat_debounce;
                bat_ok = 1'b1;
            end
        end
        else
        begin
            bat_count = '0;
            bat_ok = 1'b0;
        end

        // low test wins when the thresholds overlap
        if (ign < cfg_model.ign_low_threshold)
        begin
            ign_on = 1'b0;
            ign_count = '0;
        end
        else if (ign > cfg_model.ign_high_threshold)
        begin
            if (ign_count != {ICNT_BITS{1'b1}})
                ign_count++;
            if (ign_count > {1'b0, cfg_model.ign_debounce})
            begin
                ign_on = 1'b1;
                ign_count = IGN_HOLD_COUNT;
            end
        end

        if (pin)
        begin
            flt_on = 1'b0;
            flt_count = '0;
        end
        else if (flt_count < cfg_model.fault_debounce)
        begin
            flt_on = 1'b0;
            flt_count++;
        end
        else
            flt_on = 1'b1;

        if (ign_was_on && !ign_on)
            off_seen = 1'b1;
        else if (!ign_was_on && ign_on)
        begin
            off_seen = 1'b0;
            wake = (standby == WAKE_STANDBY);
        end
        ign_was_on = ign_on;

        flags = '{bat_ok, ign_on, flt_on, ign_on, off_seen, wake};
        return flags;
    endfunction

    function automatic void apply_register(input logic [REG_IDX_BITS-1:0] idx,
                                           input logic [31:0] word);
        case (idx)
            REG_VBAT_THRESHOLD: cfg_model.vbat_threshold     = word[SAMPLE_BITS-1:0];
            REG_VBAT_DEBOUNCE:  cfg_model.vbat_debounce      = word[DEB_BITS-1:0];
            REG_IGN_LOW:        cfg_model.ign_low_threshold  = word[SAMPLE_BITS-1:0];
            REG_IGN_HIGH:       cfg_model.ign_high_threshold = word[SAMPLE_BITS-1:0];
            REG_IGN_DEBOUNCE:   cfg_model.ign_debounce       = word[DEB_BITS-1:0];
            REG_FAULT_DEBOUNCE: cfg_model.fault_debounce     = word[DEB_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] register_value(input logic [REG_IDX_BITS-1:0] idx);
        case (idx)
            REG_VBAT_THRESHOLD: return 32'(cfg_model.vbat_threshold);
            REG_VBAT_DEBOUNCE:  return 32'(cfg_model.vbat_debounce);
            REG_IGN_LOW:        return 32'(cfg_model.ign_low_threshold);
            REG_IGN_HIGH:       return 32'(cfg_model.ign_high_threshold);
            REG_IGN_DEBOUNCE:   return 32'(cfg_model.ign_debounce);
            REG_FAULT_DEBOUNCE: return 32'(cfg_model.fault_debounce);
            default:            return '0;
        endcase
    endfunction

    // value in [lo, hi] with both ends favored; anything at all if the range is empty
    function automatic logic [SAMPLE_BITS-1:0] sample_in(input int lo, input int hi);
        if (lo > hi)
            return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        case ($urandom_range(0, 3))
            0:       return SAMPLE_BITS'(lo);
            1:       return SAMPLE_BITS'(hi);
            default: return SAMPLE_BITS'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic int run_length(input int deb);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(1, 4);
            5, 6, 7:       return deb + $urandom_range(0, 3);
            default:       return deb + $urandom_range(1, 120);
        endcase
    endfunction

    task automatic check_flag(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            $display("%0t: %s expected %b actual %b", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic drop_valid();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            if (sender_gaps_on)
            begin
                gap = $urandom_range(1, 8);
                drop_valid();
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] bat,
                               input logic [SAMPLE_BITS-1:0] ign,
                               input logic pin,
                               input logic [7:0] standby);
        in_valid <= 1'b1;
        offering = 1'b1;
        battery_sample <= bat;
        ignition_sample <= ign;
        fault_pin <= pin;
        standby_state <= standby;
        do
            @(posedge clk);
        while (!in_ready);
        flags_due.push_back(qualify_tick(bat, ign, pin, standby));
        pace_sender();
    endtask

    task automatic drain_results();
        drop_valid();
        while (flags_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] word);
        logic [31:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        apply_register(idx, word);
        want = register_value(idx);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            $display("%0t: register %0d expected %h actual %h", $time, idx, want, prdata);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        // idle the bus before the next transfer
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [31:0] vbat_thr, input logic [31:0] vbat_deb,
                                  input logic [31:0] ign_lo, input logic [31:0] ign_hi,
                                  input logic [31:0] ign_deb, input logic [31:0] flt_deb);
        drain_results();
        write_register(REG_VBAT_THRESHOLD, vbat_thr);
        write_register(REG_VBAT_DEBOUNCE, vbat_deb);
        write_register(REG_IGN_LOW, ign_lo);
        write_register(REG_IGN_HIGH, ign_hi);
        write_register(REG_IGN_DEBOUNCE, ign_deb);
        write_register(REG_FAULT_DEBOUNCE, flt_deb);
    endtask

    // runs of steady levels, some long enough to cross each debounce, with noise mixed in
    task automatic send_field_runs(input int words);
        logic [SAMPLE_BITS-1:0] bat;
        logic [SAMPLE_BITS-1:0] ign;
        logic [7:0] standby;
        int thr;
        int lo_t;
        int hi_t;
        for (int n = 0; n < words; n++)
        begin
            thr = cfg_model.vbat_threshold;
            lo_t = cfg_model.ign_low_threshold;
            hi_t = cfg_model.ign_high_threshold;
            if (bat_run <= 0)
            begin
                bat_mode = $urandom_range(0, 1);
                bat_run = run_length(cfg_model.vbat_debounce);
            end
            if (ign_run <= 0)
            begin
                ign_mode = $urandom_range(0, 2);
                ign_run = run_length(cfg_model.ign_debounce);
            end
            if (pin_run <= 0)
            begin
                pin_level = $urandom_range(0, 1);
                pin_run = run_length(cfg_model.fault_debounce);
            end
            bat_run--;
            ign_run--;
            pin_run--;
            bat = bat_mode ? sample_in(thr + 1, SAMPLE_MAX) : sample_in(0, thr);
            case (ign_mode)
                0:       ign = sample_in(0, lo_t - 1);
                1:       ign = (lo_t <= hi_t) ? sample_in(lo_t, hi_t) : sample_in(hi_t, lo_t);
                default: ign = sample_in(hi_t + 1, SAMPLE_MAX);
            endcase
            standby = $urandom_range(0, 1) ? WAKE_STANDBY : 8'($urandom);
            if ($urandom_range(0, 11) == 0)
                send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                            1'($urandom), 8'($urandom));
            else
                send_sample(bat, ign, pin_level, standby);
        end
    endtask

    task automatic test_field_extremes();
        send_sample('0, '0, 1'b1, 8'd0);
        // battery qualifies on the fourth, ignition on the eleventh with a wake
        for (int k = 0; k < 11; k++)
            send_sample(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX), k[0], WAKE_STANDBY);
        send_sample(VBAT_THRESHOLD_RST, 12'd500, 1'b0, 8'hFF);
        send_sample(VBAT_THRESHOLD_RST + 1'b1, IGN_LOW_RST, 1'b1, WAKE_STANDBY);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX), IGN_LOW_RST - 1'b1, 1'b1, 8'd0);
        send_sample('0, IGN_HIGH_RST + 1'b1, 1'b0, 8'h80);
    endtask

    task automatic test_fault_debounce();
        drain_results();
        // upper bits of the word must be dropped
        write_register(REG_FAULT_DEBOUNCE, 32'hFFFF_FF01);
        send_sample(12'd800, 12'd0, 1'b0, WAKE_STANDBY);
        send_sample(12'd800, 12'd0, 1'b0, WAKE_STANDBY);
        send_sample(12'd800, 12'd0, 1'b0, WAKE_STANDBY);
        send_sample(12'd800, 12'd0, 1'b1, WAKE_STANDBY);
    endtask

    task automatic test_threshold_overlap();
        drain_results();
        write_register(REG_IGN_LOW, 32'hABCD_0BB8);
        write_register(REG_IGN_HIGH, 32'd1000);
        write_register(REG_IGN_DEBOUNCE, 32'd0);
        send_sample(12'd100, 12'd2999, 1'b1, WAKE_STANDBY);
        send_sample(12'd100, 12'd3000, 1'b1, WAKE_STANDBY);
        send_sample(12'd100, 12'd500, 1'b1, WAKE_STANDBY);
        send_sample(12'd100, 12'hFFF, 1'b1, 8'd3);
        send_sample(12'd100, 12'd0, 1'b1, WAKE_STANDBY);
    endtask

    task automatic test_mixed_traffic();
        send_field_runs(200);
    endtask

    task automatic test_backpressure();
        drain_results();
        sender_gaps_on = 1'b0;
        result_hold_request = 60;
        send_field_runs(40);
        sender_gaps_on = 1'b1;
        drain_results();
    endtask

    task automatic test_config_floor();
        write_settings(32'hFFFF_F000, 32'h0000_0000, 32'd0, 32'h0001_0000, 32'd0, 32'hFF00);
        send_field_runs(200);
    endtask

    task automatic test_config_ceiling();
        write_settings(32'hFFF, 32'hFF, 32'hFFF, 32'hFFFF_FFFF, 32'hFF, 32'hFF);
        send_field_runs(200);
    endtask

    task automatic test_long_debounce();
        write_settings(32'd2048, 32'd254, 32'd1000, 32'd3000, 32'd255, 32'd255);
        send_field_runs(300);
    endtask

    task automatic test_random_configs();
        logic [31:0] deb [3];
        for (int pass = 0; pass < 5; pass++)
        begin
            // mostly short debounce counts so the flags move often
            for (int k = 0; k < 3; k++)
                deb[k] = ($urandom_range(0, 9) < 6) ? (($urandom & 32'hFFFF_FF00)
                                                       | $urandom_range(0, 12))
                                                    : $urandom;
            write_settings($urandom, deb[0], $urandom, $urandom, deb[1], deb[2]);
            send_field_runs(200);
        end
    endtask

    // receiver: switches between random ready patterns, long hold on request
    initial
    begin
        int ready_mode;
        int mode_left;
        int hold_left;
        int beat;
        logic ready_next;
        ready_mode = 0;
        mode_left = 0;
        hold_left = 0;
        beat = 0;
        forever
        begin
            @(posedge clk);
            beat++;
            if (result_hold_request > 0)
            begin
                hold_left = result_hold_request;
                result_hold_request = 0;
            end
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
                case (ready_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = 1'($urandom_range(0, 1));
                    2:       ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = (beat % 5) != 0;
                endcase
            out_ready <= ready_next;
        end
    end

    // compare each result word with the oldest pending expectation
    initial
    begin
        supervisor_flags_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (flags_due.size() == 0)
                begin
                    $display("%0t: result word with none pending", $time);
                    mismatches++;
                end
                else
                begin
                    want = flags_due.pop_front();
                    check_flag("battery_ok", want.battery_ok, battery_ok);
                    check_flag("ignition_on", want.ignition_on, ignition_on);
                    check_flag("regulator_fault", want.regulator_fault, regulator_fault);
                    check_flag("power_state", want.power_state, power_state);
                    check_flag("ignition_off_seen", want.off_seen, ignition_off_seen);
                    check_flag("wake_event", want.wake, wake_event);
                end
            end
        end
    end

    initial
    begin
        #2ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_fault_debounce();
        test_threshold_overlap();
        test_mixed_traffic();
        test_backpressure();
        test_config_floor();
        test_config_ceiling();
        test_long_debounce();
        test_random_configs();
        drain_results();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[power_input_supervisor_top.f]
hw/rtl/pis_pkg.sv
hw/rtl/pis_regs.sv
hw/rtl/power_input_supervisor_top.sv
tb/power_input_supervisor_top_test.sv
